// File: sv/mbfs_pkg.sv
// ----------------------------------------------------------------------------
// mbfs_pkg
// Shared widths, codes, thresholds and types for the metaball field shader.
// ----------------------------------------------------------------------------
package mbfs_pkg;

   // Field widths
   localparam int ACT_W   = 2;
   localparam int IDX_W   = 4;
   localparam int XY_W    = 12;
   localparam int V_W     = 4;
   localparam int R_W     = 6;
   localparam int PIX_W   = 10;
   localparam int DIM_W   = 10;
   localparam int SHADE_W = 2;

   // Arithmetic widths
   localparam int DXY_W   = 13;          // pixel minus ball position, signed
   localparam int PROD_W  = 2 * DXY_W;   // full signed square
   localparam int SQ_W    = 24;          // one squared distance, |d| <= 3071
   localparam int RR_W    = 2 * R_W;     // radius squared
   localparam int D2_W    = 25;          // sum of two squares
   localparam int Q_W     = 16;          // Q16 term and sum
   localparam int QCNT_W  = 4;           // divider step counter

   // Stream and register port widths
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Reset values of the display registers
   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(320);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(240);

   // Shade thresholds in Q16
   localparam logic [Q_W-1:0] TH_BLACK = 16'd42598;
   localparam logic [Q_W-1:0] TH_WHITE = 16'd32768;
   localparam logic [Q_W-1:0] TH_GREEN = 16'd26214;
   localparam logic [Q_W-1:0] Q_MAX    = 16'hFFFF;

   // Item kinds
   typedef enum logic [ACT_W-1:0] {
      ACT_LOAD  = 2'd0,
      ACT_TICK  = 2'd1,
      ACT_QUERY = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   // Shades
   typedef enum logic [SHADE_W-1:0] {
      SHADE_BACK  = 2'd0,
      SHADE_GREEN = 2'd1,
      SHADE_WHITE = 2'd2,
      SHADE_BLACK = 2'd3
   } shade_type;

   // Sequencer states
   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_TICK   = 8'b0000_0010,
      ST_FETCH  = 8'b0000_0100,
      ST_SQX    = 8'b0000_1000,
      ST_SQY    = 8'b0001_0000,
      ST_START  = 8'b0010_0000,
      ST_WAIT   = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   // Request to the shared divider
   typedef struct packed {
      logic            start;
      logic [RR_W-1:0] dividend;
      logic [D2_W-1:0] divisor;
   } div_req_type;

   // Answer of the shared divider
   typedef struct packed {
      logic           done;
      logic [Q_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: sv/mbfs_divider.sv
// ----------------------------------------------------------------------------
// mbfs_divider
// Restoring divider, one quotient bit per cycle: dividend * 2^16 / divisor,
// saturated to 16 bits.
// ----------------------------------------------------------------------------
module mbfs_divider (
   input  logic                clock,
   input  logic                reset,
   input  mbfs_pkg::div_req_type req,
   output mbfs_pkg::div_rsp_type rsp
);
   import mbfs_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic [D2_W-1:0]   rem_ff;
   logic [D2_W-1:0]   rem_in;
   logic [D2_W-1:0]   divisor_ff;
   logic [Q_W-1:0]    quot_ff;
   logic [Q_W-1:0]    quot_in;
   logic [D2_W:0]     shifted;
   logic              ge;
   logic              sat;

   // Quotient overflows 16 bits exactly when dividend >= divisor
   assign sat = {{(D2_W-RR_W){1'b0}}, req.dividend} >= req.divisor;

   // One restoring step
   always_comb begin
      shifted = {rem_ff, 1'b0};
      ge      = shifted >= {1'b0, divisor_ff};
      rem_in  = ge ? D2_W'(shifted - {1'b0, divisor_ff}) : shifted[D2_W-1:0];
      quot_in = {quot_ff[Q_W-2:0], ge};
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= !sat;
            done_ff <= sat;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == QCNT_W'(Q_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (req.start) begin
         divisor_ff <= req.divisor;
         rem_ff     <= {{(D2_W-RR_W){1'b0}}, req.dividend};
         quot_ff    <= sat ? Q_MAX : '0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quot_ff;

endmodule

// File: sv/metaball_field_shader.sv
// ----------------------------------------------------------------------------
// metaball_field_shader
// Ball table, tick animation and pixel shading by summed r^2/d^2 field.
// ----------------------------------------------------------------------------
// A load item leaves the sequencer idle; a tick moves one ball per cycle.
// In a pixel query each ball passes through fetch, the two passes through
// the shared squarer and the divider start, then waits in the shared
// 16-step restoring divider, so the divider sets the rate; a ball with zero
// radius or a saturated term skips most of the divider. The input is not
// ready while a tick or a query is in progress; a finished result waits in
// an output register, so the next item can be taken before it is read.
module metaball_field_shader #(
   parameter int BALLS = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   // Requests
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // ball_index[3:0], load_x[15:4], load_y[27:16], load_vx[31:28],
   // load_vy[35:32], load_radius[41:36], pixel_x[51:42], pixel_y[61:52]
   input  logic [mbfs_pkg::REQ_DATA_W-1:0]     req_tdata,
   // action[1:0]
   input  logic [mbfs_pkg::ACT_W-1:0]          req_tuser,
   // Results
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // shade[1:0], out_x[11:2], out_y[21:12]
   output logic [mbfs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mbfs_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mbfs_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mbfs_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import mbfs_pkg::*;

   localparam int BIDX_W = (BALLS > 1) ? $clog2(BALLS) : 1;

   // Request fields
   action_type              req_action;
   logic [IDX_W-1:0]        req_index;
   logic [XY_W-1:0]         req_x;
   logic [XY_W-1:0]         req_y;
   logic [V_W-1:0]          req_vx;
   logic [V_W-1:0]          req_vy;
   logic [R_W-1:0]          req_radius;
   logic [PIX_W-1:0]        req_px;
   logic [PIX_W-1:0]        req_py;
   logic                    req_accept;

   assign req_action = action_type'(req_tuser);
   assign req_index  = req_tdata[3:0];
   assign req_x      = req_tdata[15:4];
   assign req_y      = req_tdata[27:16];
   assign req_vx     = req_tdata[31:28];
   assign req_vy     = req_tdata[35:32];
   assign req_radius = req_tdata[41:36];
   assign req_px     = req_tdata[51:42];
   assign req_py     = req_tdata[61:52];

   // Display registers
   logic [DIM_W-1:0] width_ff;
   logic [DIM_W-1:0] height_ff;
   logic             csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2]) begin
            height_ff <= csr_pwdata[DIM_W-1:0];
         end else begin
            width_ff <= csr_pwdata[DIM_W-1:0];
         end
      end
   end

   assign csr_prdata = csr_paddr[2] ? CSR_DATA_W'(height_ff) : CSR_DATA_W'(width_ff);

   // Sequencer and working registers
   state_type           state_ff;
   state_type           state_in;
   logic [BIDX_W-1:0]   cnt_ff;
   logic                last_ball;
   logic [PIX_W-1:0]    px_ff;
   logic [PIX_W-1:0]    py_ff;
   logic signed [DXY_W-1:0] dx_ff;
   logic signed [DXY_W-1:0] dy_ff;
   logic [R_W-1:0]      r_ff;
   logic [SQ_W-1:0]     sq_ff;
   logic [D2_W-1:0]     d2_ff;
   logic [Q_W-1:0]      sum_ff;
   logic [Q_W:0]        sum_wide;
   logic                out_free;

   assign last_ball  = cnt_ff == BIDX_W'(BALLS - 1);
   assign req_tready = state_ff == ST_IDLE;
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid || rsp_tready;

   // Ball table, one entry per ball
   logic [XY_W-1:0] ball_x_ff  [BALLS];
   logic [XY_W-1:0] ball_y_ff  [BALLS];
   logic [V_W-1:0]  ball_vx_ff [BALLS];
   logic [V_W-1:0]  ball_vy_ff [BALLS];
   logic [R_W-1:0]  ball_r_ff  [BALLS];
   logic            load_we;
   logic [BIDX_W-1:0] load_idx;

   assign load_we  = req_accept && req_action == ACT_LOAD
                     && {1'b0, req_index} < (IDX_W+1)'(BALLS);
   assign load_idx = BIDX_W'(req_index);

   // Motion of the current ball during a tick
   logic [XY_W-1:0] nx;
   logic [XY_W-1:0] ny;
   logic            bounce_x;
   logic            bounce_y;

   always_comb begin
      nx = ball_x_ff[cnt_ff] + {{(XY_W-V_W){ball_vx_ff[cnt_ff][V_W-1]}}, ball_vx_ff[cnt_ff]};
      ny = ball_y_ff[cnt_ff] + {{(XY_W-V_W){ball_vy_ff[cnt_ff][V_W-1]}}, ball_vy_ff[cnt_ff]};
      // Below zero, or past the limit while positive
      bounce_x = nx[XY_W-1] || nx > {{(XY_W-DIM_W){1'b0}}, width_ff};
      bounce_y = ny[XY_W-1] || ny > {{(XY_W-DIM_W){1'b0}}, height_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BALLS; i++) begin
            ball_x_ff[i]  <= '0;
            ball_y_ff[i]  <= '0;
            ball_vx_ff[i] <= '0;
            ball_vy_ff[i] <= '0;
            ball_r_ff[i]  <= '0;
         end
      end else if (load_we) begin
         ball_x_ff[load_idx]  <= req_x;
         ball_y_ff[load_idx]  <= req_y;
         ball_vx_ff[load_idx] <= req_vx;
         ball_vy_ff[load_idx] <= req_vy;
         ball_r_ff[load_idx]  <= req_radius;
      end else if (state_ff == ST_TICK) begin
         ball_x_ff[cnt_ff] <= nx;
         ball_y_ff[cnt_ff] <= ny;
         if (bounce_x) begin
            ball_vx_ff[cnt_ff] <= V_W'(-ball_vx_ff[cnt_ff]);
         end
         if (bounce_y) begin
            ball_vy_ff[cnt_ff] <= V_W'(-ball_vy_ff[cnt_ff]);
         end
      end
   end

   // Shared squarer
   logic signed [DXY_W-1:0]  mul_a;
   logic signed [PROD_W-1:0] prod;

   assign mul_a = (state_ff == ST_SQY) ? dy_ff : dx_ff;
   assign prod  = PROD_W'(mul_a) * PROD_W'(mul_a);

   // Shared divider
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign div_req.start    = state_ff == ST_START && r_ff != '0;
   assign div_req.dividend = RR_W'(r_ff) * RR_W'(r_ff);
   assign div_req.divisor  = d2_ff;

   mbfs_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign sum_wide = {1'b0, sum_ff} + {1'b0, div_rsp.quotient};

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_action == ACT_TICK) begin
                  state_in = ST_TICK;
               end else if (req_action == ACT_QUERY) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_TICK:   state_in = last_ball ? ST_IDLE : ST_TICK;
         ST_FETCH:  state_in = ST_SQX;
         ST_SQX:    state_in = ST_SQY;
         ST_SQY:    state_in = ST_START;
         ST_START: begin
            if (r_ff != '0) begin
               state_in = ST_WAIT;
            end else begin
               state_in = last_ball ? ST_FINISH : ST_FETCH;
            end
         end
         ST_WAIT: begin
            if (div_rsp.done) begin
               state_in = last_ball ? ST_FINISH : ST_FETCH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (req_accept) begin
            cnt_ff <= '0;
         end else if ((state_ff == ST_TICK && !last_ball)
                      || (state_ff == ST_START && r_ff == '0 && !last_ball)
                      || (state_ff == ST_WAIT && div_rsp.done && !last_ball)) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   // Query datapath
   always_ff @(posedge clock) begin
      if (req_accept) begin
         px_ff  <= req_px;
         py_ff  <= req_py;
         sum_ff <= '0;
      end
      if (state_ff == ST_FETCH) begin
         dx_ff <= $signed({{(DXY_W-PIX_W){1'b0}}, px_ff})
                  - $signed({ball_x_ff[cnt_ff][XY_W-1], ball_x_ff[cnt_ff]});
         dy_ff <= $signed({{(DXY_W-PIX_W){1'b0}}, py_ff})
                  - $signed({ball_y_ff[cnt_ff][XY_W-1], ball_y_ff[cnt_ff]});
         r_ff  <= ball_r_ff[cnt_ff];
      end
      if (state_ff == ST_SQX) begin
         sq_ff <= prod[SQ_W-1:0];
      end
      if (state_ff == ST_SQY) begin
         d2_ff <= {1'b0, sq_ff} + {1'b0, prod[SQ_W-1:0]};
      end
      // Saturating accumulate of one term
      if (state_ff == ST_WAIT && div_rsp.done) begin
         sum_ff <= sum_wide[Q_W] ? Q_MAX : sum_wide[Q_W-1:0];
      end
   end

   // Output register
   shade_type        shade;
   logic             rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   always_comb begin
      if (sum_ff > TH_BLACK) begin
         shade = SHADE_BLACK;
      end else if (sum_ff > TH_WHITE) begin
         shade = SHADE_WHITE;
      end else if (sum_ff > TH_GREEN) begin
         shade = SHADE_GREEN;
      end else begin
         shade = SHADE_BACK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_FINISH && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FINISH && out_free) begin
         rsp_data_ff <= RSP_DATA_W'({py_ff, px_ff, shade});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
